### hw/rtl/echpi_pkg.sv
// Shared types, port codes and reset contents for the EC host port interface.
`default_nettype none

package echpi_pkg;

	localparam logic [15:0] PORT_CMD    = 16'h0066;
	localparam logic [15:0] PORT_DATA   = 16'h0062;
	localparam logic [7:0]  CMD_READ    = 8'h80;
	localparam logic [7:0]  CMD_WRITE   = 8'h81;
	localparam logic [7:0]  STATUS_OBF  = 8'h01;
	localparam logic [7:0]  STATUS_NONE = 8'h00;
	localparam logic [7:0]  REG_DEFAULT = 8'h80;

	localparam logic        REQ_READ    = 1'b0;
	localparam logic        REQ_WRITE   = 1'b1;

	localparam int unsigned RF_DEPTH    = 256;
	localparam int unsigned RF_AW       = $clog2(RF_DEPTH);

	localparam int unsigned APB_AW      = 2;
	localparam logic [APB_AW-1:0] REG_PORT_EN_ADDR = '0;

	// Control from the sequencer to the register file for one transaction.
	typedef struct packed {
		logic             issue;
		logic             access_ok;
		logic             rd_from_mem;
		logic [7:0]       rd_val;
		logic             wr_en;
		logic [RF_AW-1:0] addr;
		logic [7:0]       wr_data;
	} rf_ctl_t;

	function automatic logic [7:0] reg_reset_val(input logic [RF_AW-1:0] a);
		logic [7:0] v;
		case (a)
			8'h78:   v = 8'd55;
			8'h7A:   v = 8'd48;
			8'h7B:   v = 8'd60;
			8'h7C:   v = 8'd42;
			8'h7E:   v = 8'd40;
			8'hC0:   v = 8'd50;
			8'hC1:   v = 8'd45;
			8'hC2:   v = 8'd38;
			8'h84:   v = 8'hA0;
			8'h85:   v = 8'h09;
			8'h31:   v = 8'h00;
			default: v = REG_DEFAULT;
		endcase
		return v;
	endfunction

endpackage

`default_nettype wire

### hw/rtl/echpi_apb_regs.sv
// APB configuration register holding the port enable bit.
`default_nettype none

module echpi_apb_regs
	import echpi_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [APB_AW-1:0] paddr,
	input  wire logic [31:0]       pwdata,
	output logic      [31:0]       prdata,
	output logic                   pready,
	output logic                   port_enabled
);

	logic port_enabled_q;
	logic wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && (paddr == REG_PORT_EN_ADDR);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			port_enabled_q <= 1'b0;
		end else if (wr_en) begin
			port_enabled_q <= pwdata[0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr == REG_PORT_EN_ADDR) begin
			prdata[0] = port_enabled_q;
		end
	end

	assign port_enabled = port_enabled_q;

endmodule

`default_nettype wire

### hw/rtl/echpi_seq.sv
// Input register and command/data sequence state machine.
`default_nettype none

module echpi_seq
	import echpi_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        accept,
	input  wire logic        req_type,
	input  wire logic [15:0] port_addr,
	input  wire logic [7:0]  wr_byte,
	input  wire logic        port_enabled,
	output rf_ctl_t          ctl
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ_OFFSET,
		ST_READ_DATA,
		ST_WRITE_OFFSET,
		ST_WRITE_DATA
	} seq_state_t;

	seq_state_t       state_q;
	seq_state_t       state_d;
	logic [RF_AW-1:0] offset_q;
	logic [RF_AW-1:0] offset_d;

	logic             valid_s1;
	logic             req_type_s1;
	logic [15:0]      port_addr_s1;
	logic [7:0]       wr_byte_s1;

	logic             exec;
	logic             is_cmd;
	logic             is_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_type_s1  <= req_type;
			port_addr_s1 <= port_addr;
			wr_byte_s1   <= wr_byte;
		end
	end

	assign exec    = valid_s1 && port_enabled;
	assign is_cmd  = (port_addr_s1 == PORT_CMD);
	assign is_data = (port_addr_s1 == PORT_DATA);

	always_comb begin
		state_d         = state_q;
		offset_d        = offset_q;
		ctl.issue       = valid_s1;
		ctl.access_ok   = port_enabled;
		ctl.rd_from_mem = 1'b0;
		ctl.rd_val      = '0;
		ctl.wr_en       = 1'b0;
		ctl.addr        = offset_q;
		ctl.wr_data     = wr_byte_s1;
		if (exec) begin
			if (req_type_s1 == REQ_READ) begin
				if (is_cmd) begin
					ctl.rd_val = (state_q == ST_READ_DATA) ? STATUS_OBF : STATUS_NONE;
				end else if (is_data && (state_q == ST_READ_DATA)) begin
					ctl.rd_from_mem = 1'b1;
					state_d         = ST_IDLE;
				end
			end else if (is_cmd) begin
				if (wr_byte_s1 == CMD_READ) begin
					state_d = ST_READ_OFFSET;
				end else if (wr_byte_s1 == CMD_WRITE) begin
					state_d = ST_WRITE_OFFSET;
				end
			end else if (is_data) begin
				case (state_q)
					ST_READ_OFFSET: begin
						offset_d = wr_byte_s1;
						state_d  = ST_READ_DATA;
					end
					ST_WRITE_OFFSET: begin
						offset_d = wr_byte_s1;
						state_d  = ST_WRITE_DATA;
					end
					ST_WRITE_DATA: begin
						ctl.wr_en = 1'b1;
						state_d   = ST_IDLE;
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			offset_q <= '0;
		end else begin
			state_q  <= state_d;
			offset_q <= offset_d;
		end
	end

	a_read_needs_data_state: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.rd_from_mem |-> (state_q == ST_READ_DATA) && exec)
		else $error("Register file read outside the read data phase.");

	a_write_needs_data_state: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.wr_en |-> (state_q == ST_WRITE_DATA) && exec)
		else $error("Register file write outside the write data phase.");

	a_read_returns_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.rd_from_mem |=> (state_q == ST_IDLE))
		else $error("Sequence did not return to idle after a data read.");

	a_disabled_no_change: assert property (@(posedge clk) disable iff (!arst_n)
		!port_enabled |=> $stable(state_q) && $stable(offset_q))
		else $error("Sequence state changed while the port was disabled.");

endmodule

`default_nettype wire

### hw/rtl/echpi_regfile.sv
// Register file with reset-value tracking and the registered result stage.
`default_nettype none

module echpi_regfile
	import echpi_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire rf_ctl_t ctl,
	output logic         done,
	output logic [7:0]   rd_byte,
	output logic         access_ok
);

	logic [7:0]          mem_q [RF_DEPTH];
	logic [RF_DEPTH-1:0] written_q;

	logic                done_s2;
	logic [7:0]          rd_byte_s2;
	logic                access_ok_s2;

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem_q[ctl.addr] <= ctl.wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q <= '0;
		end else if (ctl.wr_en) begin
			written_q[ctl.addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s2 <= 1'b0;
		end else begin
			done_s2 <= ctl.issue;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.issue) begin
			access_ok_s2 <= ctl.access_ok;
			if (ctl.rd_from_mem) begin
				rd_byte_s2 <= written_q[ctl.addr] ? mem_q[ctl.addr] : reg_reset_val(ctl.addr);
			end else begin
				rd_byte_s2 <= ctl.rd_val;
			end
		end
	end

	assign done      = done_s2;
	assign rd_byte   = rd_byte_s2;
	assign access_ok = access_ok_s2;

endmodule

`default_nettype wire

### hw/rtl/ec_host_port_interface.sv
// Top level of the EC host port interface: command/status and data port model.
//
// Each transaction is one host port access: req_type (0 read, 1 write),
// port_addr (0x66 command/status, 0x62 data) and wr_byte. A transaction
// is accepted at a rising edge with start high and busy low; busy is never
// raised, so one transaction can be accepted in every cycle.
// The transaction is captured in an input register, decoded against the
// sequence state in the following cycle, and its result (rd_byte,
// access_ok) is registered at the next edge and shown with done high for
// exactly one cycle; it is taken at the rising edge that ends that cycle.
// Results leave in acceptance order; the receiver cannot
// stall them and must take each one in the cycle it is shown.
// The APB port holds port_enabled at address 0; while it is low every
// transaction returns rd_byte 0 and access_ok 0 and changes nothing.
// Reset clears the enable, returns the sequence to idle with offset zero,
// and restores the 256-byte register file to its default contents at once,
// so the first transaction may be accepted in the first cycle after reset.
`default_nettype none

module ec_host_port_interface
	import echpi_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire logic              req_type,
	input  wire logic [15:0]       port_addr,
	input  wire logic [7:0]        wr_byte,
	output logic                   done,
	output logic [7:0]             rd_byte,
	output logic                   access_ok,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [APB_AW-1:0] paddr,
	input  wire logic [31:0]       pwdata,
	output logic      [31:0]       prdata,
	output logic                   pready
);

	logic    port_enabled;
	logic    accept;
	rf_ctl_t ctl;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	echpi_apb_regs u_regs (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.port_enabled (port_enabled)
	);

	echpi_seq u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.req_type     (req_type),
		.port_addr    (port_addr),
		.wr_byte      (wr_byte),
		.port_enabled (port_enabled),
		.ctl          (ctl)
	);

	echpi_regfile u_rf (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.done      (done),
		.rd_byte   (rd_byte),
		.access_ok (access_ok)
	);

	a_done_follows_accept: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, 2))
		else $error("Result strobe without a matching accepted transaction.");

	a_accept_gives_done: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> ##1 done)
		else $error("Accepted transaction produced no result.");

	a_disabled_result: assert property (@(posedge clk) disable iff (!arst_n)
		done && !access_ok |-> (rd_byte == '0))
		else $error("Failed access returned non-zero data.");

endmodule

`default_nettype wire
